/* sv/gccd_pkg.sv */
package gccd_pkg;

    // table depth must be a power of two: probe addresses and the clearing sweep wrap on it
    localparam int unsigned TableEntries = 1024;
    localparam int unsigned CoordW       = 20;
    localparam int unsigned SizeW        = 16;
    localparam int unsigned CountW       = 8;
    localparam int unsigned CfgIdxW      = 8;

    localparam logic [SizeW-1:0]  CellSizeReset = 16'd100;
    localparam logic [CountW-1:0] MaxCellReset  = 8'd1;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] RegCellSize = 8'd0;
    localparam logic [CfgIdxW-1:0] RegMaxCell  = 8'd1;

    // controller to datapath commands
    typedef struct packed {
        logic load;      // capture point, start dividers
        logic div_step;  // one quotient bit
        logic div_fix;   // floor correction
        logic hash;      // compute first probe address
        logic rd;        // issue table read (cell entry)
        logic next;      // advance probe address
        logic wr;        // write back entry
        logic out_load;  // capture result
        logic clr_start; // begin clearing sweep
        logic clr_step;  // clear one entry
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic div_done;
        logic hit;
        logic empty;
        logic wrapped;   // probed every entry
        logic clr_done;
        logic new_cloud;
    } t_sts;

    // cell hash over the low 20 bits of both cell coordinates
    function automatic logic [31:0] cell_hash(input logic [CoordW-1:0] a,
                                              input logic [CoordW-1:0] b);
        logic [31:0] ha;
        logic [31:0] hb;
        ha = {12'd0, a} * 32'd2654435761;
        hb = {12'd0, b} * 32'd40503;
        return ha ^ hb ^ ({12'd0, b} << 7);
    endfunction

endpackage

/* sv/grid_cell_capped_downsampler.sv */
// Channel   | Dir | Transfer           | Payload
// s_axis    | in  | tvalid & tready    | tdata: point_x, point_y; tuser: new_cloud
// m_axis    | out | tvalid & tready    | tdata: out_x, out_y; tuser: keep, table_full
// cfg       | in  | valid & ready      | index, data; ready only while idle
// A point passes the 20-step divider, a floor correction and a probe of P table entries
// (1 to TABLE_ENTRIES) before the next one is accepted.
// A new_cloud point first sweeps the table clear before its probe.
// After reset the same sweep runs before s_axis_tready rises.
// A result waits in the output register while the next point is taken; a second
// finished result holds the controller until the first one leaves.
module grid_cell_capped_downsampler #(
    parameter int unsigned TABLE_ENTRIES = gccd_pkg::TableEntries
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // point_x[19:0], point_y[39:20]
    input  logic        s_axis_tuser,  // new_cloud
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // out_x[19:0], out_y[39:20]
    output logic [1:0]  m_axis_tuser,  // keep[0], table_full[1]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [gccd_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    gccd_pkg::t_cmd cmd;
    gccd_pkg::t_sts sts;
    logic busy, keep, full, in_fire;
    logic [19:0] px, py;
    logic [15:0] r_cell_size;
    logic [7:0]  r_max_cell;

    assign s_axis_tready = !busy;
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready = !busy;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_size <= gccd_pkg::CellSizeReset;
            r_max_cell  <= gccd_pkg::MaxCellReset;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                gccd_pkg::RegCellSize: r_cell_size <= i_cfg_data;
                gccd_pkg::RegMaxCell:  r_max_cell  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    gccd_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_fire(in_fire),
        .i_out_free(!m_axis_tvalid || m_axis_tready),
        .i_sts(sts), .o_cmd(cmd), .o_busy(busy)
    );

    gccd_dp #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_sts(sts),
        .i_x(s_axis_tdata[19:0]), .i_y(s_axis_tdata[39:20]), .i_new_cloud(s_axis_tuser),
        .i_cell_size(r_cell_size), .i_max_cell(r_max_cell),
        .o_keep(keep), .o_full(full), .o_px(px), .o_py(py)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tvalid <= 1'b0;
        end else begin
            if (cmd.out_load) m_axis_tvalid <= 1'b1;
            else if (m_axis_tready) m_axis_tvalid <= 1'b0;
        end
        if (cmd.out_load) begin
            m_axis_tdata <= {py, px};
            m_axis_tuser <= {full, keep};
        end
    end

endmodule

/* sv/gccd_ctrl.sv */
module gccd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_fire,
    input  logic          i_out_free,
    input  gccd_pkg::t_sts i_sts,
    output gccd_pkg::t_cmd o_cmd,
    output logic          o_busy
);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_DIV, S_FIX, S_CLR, S_RD, S_PROBE, S_OUT
    } t_state;

    t_state r_state, n_state;
    gccd_pkg::t_cmd n_cmd;

    // next state and the commands for the current cycle
    always_comb begin
        n_state = r_state;
        n_cmd   = '0;
        unique case (r_state)
            S_INIT: begin
                // table sweep after reset
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end else begin
                    n_cmd.clr_step = 1'b1;
                end
            end
            S_IDLE: begin
                if (i_in_fire) begin
                    n_cmd.load = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_cmd.div_fix = 1'b1;
                    n_state = S_FIX;
                end else begin
                    n_cmd.div_step = 1'b1;
                end
            end
            S_FIX: begin
                if (i_sts.new_cloud) begin
                    n_cmd.clr_start = 1'b1;
                    n_state = S_CLR;
                end else begin
                    n_cmd.hash = 1'b1;
                    n_state = S_RD;
                end
            end
            S_CLR: begin
                if (i_sts.clr_done) begin
                    n_cmd.hash = 1'b1;
                    n_state = S_RD;
                end else begin
                    n_cmd.clr_step = 1'b1;
                end
            end
            S_RD: begin
                n_cmd.rd = 1'b1;
                n_state = S_PROBE;
            end
            S_PROBE: begin
                if (i_sts.empty || i_sts.hit || i_sts.wrapped) begin
                    n_cmd.wr = 1'b1;
                    n_state = S_OUT;
                end else begin
                    n_cmd.next = 1'b1;
                    n_state = S_RD;
                end
            end
            S_OUT: begin
                if (i_out_free) begin
                    n_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_INIT;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd  = n_cmd;
    assign o_busy = (r_state != S_IDLE);

endmodule

/* sv/gccd_dp.sv */
module gccd_dp #(
    parameter int unsigned TABLE_ENTRIES = gccd_pkg::TableEntries
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  gccd_pkg::t_cmd                i_cmd,
    output gccd_pkg::t_sts                o_sts,
    input  logic [gccd_pkg::CoordW-1:0]   i_x,
    input  logic [gccd_pkg::CoordW-1:0]   i_y,
    input  logic                          i_new_cloud,
    input  logic [gccd_pkg::SizeW-1:0]    i_cell_size,
    input  logic [gccd_pkg::CountW-1:0]   i_max_cell,
    output logic                          o_keep,
    output logic                          o_full,
    output logic [gccd_pkg::CoordW-1:0]   o_px,
    output logic [gccd_pkg::CoordW-1:0]   o_py
);
    localparam int unsigned AW = $clog2(TABLE_ENTRIES);
    localparam int unsigned CW = gccd_pkg::CoordW;
    localparam int unsigned SW = gccd_pkg::SizeW;
    localparam int unsigned KW = gccd_pkg::CountW;
    localparam int unsigned EW = 1 + 2*CW + KW;
    localparam int unsigned BW = $clog2(CW + 1);

    // captured point
    logic [CW-1:0] r_px, r_py;
    logic          r_nc;
    logic [SW-1:0] r_div;

    // restoring dividers on magnitudes, one bit per cycle for both axes
    logic [CW-1:0] r_qx, r_qy;
    logic [SW-1:0] r_rx, r_ry;
    logic [BW-1:0] r_bit;
    logic [CW-1:0] r_cx, r_cy;

    logic [SW:0]   n_rx, n_ry;
    logic [SW:0]   tx, ty;
    logic          gx, gy;
    logic [CW-1:0] mx, my;

    // probe
    logic [AW-1:0] r_addr;
    logic [AW-1:0] r_tries;
    logic [EW-1:0] r_rd;
    logic [AW:0]   r_clr;

    // entry: valid, cell x, cell y, count
    logic [EW-1:0] mem [TABLE_ENTRIES];

    logic [AW-1:0] h;
    logic [KW-1:0] cnt, upd_cnt;
    logic          hit, empty, wrap, upd;

    assign mx = i_x[CW-1] ? (~i_x + 1'b1) : i_x;
    assign my = i_y[CW-1] ? (~i_y + 1'b1) : i_y;
    assign tx = {r_rx, r_qx[CW-1]};
    assign ty = {r_ry, r_qy[CW-1]};
    assign gx = (tx >= {1'b0, r_div});
    assign gy = (ty >= {1'b0, r_div});

    always_comb begin
        n_rx = gx ? (tx - {1'b0, r_div}) : tx;
        n_ry = gy ? (ty - {1'b0, r_div}) : ty;
    end

    // floored quotient from magnitude quotient and remainder
    function automatic logic [CW-1:0] floor_q(input logic neg, input logic [CW-1:0] q,
                                              input logic rnz);
        if (!neg) return q;
        if (rnz) return ~q;  // -(q+1)
        return ~q + 1'b1;
    endfunction

    // divider and capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px  <= i_x;
            r_py  <= i_y;
            r_nc  <= i_new_cloud;
            r_div <= (i_cell_size == '0) ? SW'(1) : i_cell_size;
            r_qx  <= mx;
            r_qy  <= my;
            r_rx  <= '0;
            r_ry  <= '0;
        end else if (i_cmd.div_step) begin
            r_rx <= n_rx[SW-1:0];
            r_ry <= n_ry[SW-1:0];
            r_qx <= {r_qx[CW-2:0], gx};
            r_qy <= {r_qy[CW-2:0], gy};
        end
        if (i_cmd.div_fix) begin
            r_cx <= floor_q(r_px[CW-1], r_qx, r_rx != '0);
            r_cy <= floor_q(r_py[CW-1], r_qy, r_ry != '0);
        end
    end

    // bit counter: loaded with the quotient width, counts down while stepping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= '0;
        end else if (i_cmd.load) begin
            r_bit <= BW'(CW);
        end else if (i_cmd.div_step) begin
            r_bit <= r_bit - 1'b1;
        end
    end

    assign h = AW'(gccd_pkg::cell_hash(r_cx, r_cy));

    // probe address and try counter
    always_ff @(posedge i_clk) begin
        if (i_cmd.hash) begin
            r_addr  <= h;
            r_tries <= '0;
        end else if (i_cmd.next) begin
            r_addr  <= r_addr + 1'b1;
            r_tries <= r_tries + 1'b1;
        end
    end

    // clearing sweep counter, one entry per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_start) begin
            r_clr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    assign cnt     = r_rd[KW-1:0];
    assign empty   = !r_rd[EW-1];
    assign hit     = r_rd[EW-1] && r_rd[EW-2 -: CW] == r_cx && r_rd[KW +: CW] == r_cy;
    assign wrap    = !empty && !hit && (r_tries == '1);
    assign upd     = i_cmd.wr && (empty || (hit && cnt < i_max_cell));
    assign upd_cnt = empty ? KW'(1) : cnt + 1'b1;

    // table memory, registered read, one write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd <= mem[r_addr];
        end
        if (i_cmd.clr_step) begin
            mem[r_clr[AW-1:0]] <= '0;
        end else if (upd) begin
            mem[r_addr] <= {1'b1, r_cx, r_cy, upd_cnt};
        end
    end

    // result capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            o_px   <= r_px;
            o_py   <= r_py;
            o_keep <= empty || (hit && cnt < i_max_cell) || wrap;
            o_full <= wrap;
        end
    end

    assign o_sts.div_done  = (r_bit == '0);
    assign o_sts.hit       = hit;
    assign o_sts.empty     = empty;
    assign o_sts.wrapped   = wrap;
    assign o_sts.clr_done  = r_clr[AW];
    assign o_sts.new_cloud = r_nc;

endmodule

/* sv/gccd_checker.sv */
module gccd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [1:0]  m_axis_tuser
);
    // a full table always keeps the point
    a_full_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0]) else $error("full not kept");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tuser))
        else $error("result dropped");

    // accepting a point closes the input until its work is done
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("second point taken");
endmodule

bind grid_cell_capped_downsampler gccd_checker u_chk (.*);

/* tb/grid_cell_capped_downsampler_tb.sv */
module grid_cell_capped_downsampler_tb;

    localparam int unsigned Entries = gccd_pkg::TableEntries;

    typedef struct packed {
        logic        new_cloud;
        logic [19:0] py;
        logic [19:0] px;
    } t_point;

    typedef struct packed {
        logic        keep;
        logic        full;
        logic [19:0] ox;
        logic [19:0] oy;
    } t_verdict;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [gccd_pkg::CfgIdxW-1:0] i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    grid_cell_capped_downsampler dut (
        .i_clk, .i_rst_n,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data
    );

    always #10 i_clk = ~i_clk;

    // predictor state: cell table and registers
    logic [15:0] cell_edge;
    logic [7:0]  cell_cap;
    logic        occ_valid [Entries];
    int          occ_cx    [Entries];
    int          occ_cy    [Entries];
    int unsigned occ_count [Entries];

    t_point   pending_points[$];
    t_verdict expected_verdicts[$];
    int       errors = 0;
    int       sent = 0, checked = 0, kept_cnt = 0, full_cnt = 0;
    int       hold_cycles = 0;
    bit       sender_paused = 0;
    bit       in_acc = 0;

    function automatic int floor_cell(input logic signed [19:0] v, input int d);
        longint q;
        longint r;
        q = longint'(v) / d;
        r = longint'(v) % d;
        if (r != 0 && v < 0) q = q - 1;
        return int'(q);
    endfunction

    function automatic int unsigned slot_of(input int cx, input int cy);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] h;
        a = cx & 32'hFFFFF;
        b = cy & 32'hFFFFF;
        h = (a * 32'd2654435761) ^ (b * 32'd40503) ^ (b << 7);
        return h % Entries;
    endfunction

    // thinning decision for one point, updates the table copy
    function automatic t_verdict thin_point(input t_point p);
        t_verdict v;
        int d, cx, cy;
        int unsigned pos;
        bit done;
        d = (cell_edge == 0) ? 1 : int'(cell_edge);
        cx = floor_cell(p.px, d);
        cy = floor_cell(p.py, d);
        if (p.new_cloud) foreach (occ_valid[i]) occ_valid[i] = 1'b0;
        v = '0;
        v.ox = p.px;
        v.oy = p.py;
        done = 0;
        pos = slot_of(cx, cy);
        for (int n = 0; n < Entries && !done; n++) begin
            if (!occ_valid[pos]) begin
                occ_valid[pos] = 1'b1;
                occ_cx[pos] = cx;
                occ_cy[pos] = cy;
                occ_count[pos] = 1;
                v.keep = 1'b1;
                done = 1;
            end else if (occ_cx[pos] == cx && occ_cy[pos] == cy) begin
                if (occ_count[pos] < cell_cap) begin
                    occ_count[pos]++;
                    v.keep = 1'b1;
                end
                done = 1;
            end else begin
                pos = (pos + 1) % Entries;
            end
        end
        if (!done) begin
            v.keep = 1'b1;
            v.full = 1'b1;
        end
        return v;
    endfunction

    // input acceptance seen at the rising edge
    always @(posedge i_clk) in_acc <= s_axis_tvalid && s_axis_tready;

    // driver: bursts with random gaps
    int burst_left = 0, gap_left = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && !in_acc) begin
                // hold current transaction
            end else if (!sender_paused && pending_points.size() > 0 && gap_left == 0) begin
                t_point p;
                t_verdict v;
                p = pending_points.pop_front();
                v = thin_point(p);
                expected_verdicts = {expected_verdicts, v};
                s_axis_tdata <= {p.py, p.px};
                s_axis_tuser <= p.new_cloud;
                s_axis_tvalid <= 1'b1;
                sent++;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 30);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                end else begin
                    burst_left--;
                end
            end else begin
                s_axis_tvalid <= 1'b0;
                if (gap_left > 0) gap_left--;
            end
        end
    end

    // receiver stall pattern, with a long hold-off when requested
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 3) != 0) || ((sent / 200) % 3 == 1);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_verdicts.size() == 0) begin
                $error("result with no expectation: tdata=%h", m_axis_tdata);
                errors++;
            end else begin
                t_verdict e;
                e = expected_verdicts.pop_front();
                if (m_axis_tdata[19:0] !== e.ox) begin
                    $error("out_x expected %h got %h", e.ox, m_axis_tdata[19:0]);
                    errors++;
                end
                if (m_axis_tdata[39:20] !== e.oy) begin
                    $error("out_y expected %h got %h", e.oy, m_axis_tdata[39:20]);
                    errors++;
                end
                if (m_axis_tuser[0] !== e.keep) begin
                    $error("keep expected %b got %b (x=%h y=%h)", e.keep,
                           m_axis_tuser[0], e.ox, e.oy);
                    errors++;
                end
                if (m_axis_tuser[1] !== e.full) begin
                    $error("table_full expected %b got %b", e.full, m_axis_tuser[1]);
                    errors++;
                end
                checked++;
                kept_cnt += e.keep;
                full_cnt += e.full;
            end
        end
    end

    task automatic wait_drained();
        while (pending_points.size() > 0 || s_axis_tvalid || expected_verdicts.size() > 0)
            @(posedge i_clk);
        // settle before touching the registers
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [gccd_pkg::CfgIdxW-1:0] idx,
                             input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data <= val;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == gccd_pkg::RegCellSize) cell_edge = val;
        else if (idx == gccd_pkg::RegMaxCell) cell_cap = val[7:0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [19:0] rand_coord(input int span);
        if (span == 0) return 20'($urandom);
        return 20'($urandom_range(0, 2 * span) - span);
    endfunction

    task automatic add_point(input logic [19:0] x, input logic [19:0] y, input logic nc);
        t_point p;
        p.px = x;
        p.py = y;
        p.new_cloud = nc;
        pending_points = {pending_points, p};
    endtask

    // random cloud: clustered points so cells repeat and fill up to the cap
    task automatic add_cloud(input int n, input int span);
        for (int i = 0; i < n; i++)
            add_point(rand_coord(span), rand_coord(span),
                      (i == 0) || ($urandom_range(0, 199) == 0));
    endtask

    initial begin
        int base;
        cell_edge = gccd_pkg::CellSizeReset;
        cell_cap = gccd_pkg::MaxCellReset;
        foreach (occ_valid[i]) occ_valid[i] = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset settings, extremes, negative floor, cap
        add_point(20'h00000, 20'h00000, 1'b0);
        add_point(20'h00001, 20'h00063, 1'b0);
        add_point(20'hFFFFF, 20'hFFFFF, 1'b0);
        add_point(20'h80000, 20'h7FFFF, 1'b0);
        add_point(20'h7FFFF, 20'h80000, 1'b0);
        add_point(20'hFFF9C, 20'h00064, 1'b0);
        add_point(20'hFFF9B, 20'h00064, 1'b0);
        add_point(20'h00000, 20'h00000, 1'b1);
        add_point(20'h00005, 20'h00005, 1'b0);
        wait_drained();

        // zero cell size acts as one, cap at its top
        write_reg(gccd_pkg::RegCellSize, 16'd0);
        write_reg(gccd_pkg::RegMaxCell, 16'd255);
        add_point(20'h00003, 20'hFFFFD, 1'b1);
        add_point(20'h00003, 20'hFFFFD, 1'b0);
        add_point(20'h00004, 20'hFFFFD, 1'b0);
        wait_drained();

        // zero cap and widest cells
        write_reg(gccd_pkg::RegMaxCell, 16'd0);
        write_reg(gccd_pkg::RegCellSize, 16'hFFFF);
        add_point(20'h12345, 20'h54321, 1'b1);
        add_point(20'h12346, 20'h54320, 1'b0);
        add_point(20'h80000, 20'h80000, 1'b0);
        add_point(20'h80000, 20'hFFFFF, 1'b0);
        wait_drained();

        // fill the table: cell size 1, unique cells, then overflow
        write_reg(gccd_pkg::RegCellSize, 16'd1);
        write_reg(gccd_pkg::RegMaxCell, 16'd1);
        for (int i = 0; i < Entries + 6; i++)
            add_point(20'(i), 20'(i * 3), i == 0);
        add_point(20'd5, 20'd15, 1'b0);
        wait_drained();

        // long receiver hold-off with the sender still offering
        write_reg(gccd_pkg::RegCellSize, 16'd50);
        write_reg(gccd_pkg::RegMaxCell, 16'd3);
        add_cloud(60, 400);
        hold_cycles = 3000;
        wait_drained();

        // random phases across settings, sender paused mid-cloud until all results return
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(gccd_pkg::RegCellSize,
                      (ph == 5) ? 16'hFFFF : 16'($urandom_range(1, 2000)));
            write_reg(gccd_pkg::RegMaxCell,
                      (ph == 4) ? 16'd255 : 16'($urandom_range(1, 6)));
            base = sent;
            add_cloud(50, (ph == 3) ? 0 : $urandom_range(500, 20000));
            while (sent < base + 15) @(posedge i_clk);
            sender_paused = 1;
            while (expected_verdicts.size() > 0) @(posedge i_clk);
            repeat (20) @(posedge i_clk);
            sender_paused = 0;
            wait_drained();
        end

        if (checked != sent) begin
            $error("results checked %0d, points sent %0d", checked, sent);
            errors++;
        end
        $display("Covered %0d points, %0d results checked, %0d kept, %0d table-full.",
                 sent, checked, kept_cnt, full_cnt);
        if (errors == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

    initial begin
        #2000000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

/* sim.f */
sv/gccd_pkg.sv
sv/gccd_ctrl.sv
sv/gccd_dp.sv
sv/grid_cell_capped_downsampler.sv
sv/gccd_checker.sv
tb/grid_cell_capped_downsampler_tb.sv
